// File: rtl/teq_pkg.sv
// shared types and constants for the timed step event queue
package teq_pkg;

  localparam int unsigned QueueSizeDef = 256;
  localparam logic [31:0] FutureWindowUs = 32'd1000000;
  localparam int unsigned AxisTheta = 0;
  localparam int unsigned AxisRho = 1;
  localparam logic [7:0] DepthMax = 8'd255;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  // one stored event, 36 bits
  typedef struct packed {
    logic [31:0] exec_time;
    logic [1:0]  step_mask;
    logic [1:0]  dir_mask;
  } event_t;

  typedef struct packed {
    logic [1:0]  cmd;
    event_t      ev;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic               push_accepted;
    logic               fired;
    logic [1:0]         step_pulse;
    logic [1:0]         dir_pins;
    logic signed [31:0] theta_position;
    logic signed [31:0] rho_position;
    logic [7:0]         queue_depth;
    logic [31:0]        underrun_count;
  } result_t;

endpackage

// File: rtl/teq_store.sv
// event memory with one write port and a registered read port with write bypass
module teq_store
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_SIZE = QueueSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [$clog2(QUEUE_SIZE)-1:0] waddr_i,
  input  event_t                        wdata_i,
  input  logic [$clog2(QUEUE_SIZE)-1:0] raddr_i,
  output event_t                        head_o
);

  event_t mem [QUEUE_SIZE];
  event_t rdata_q;
  event_t wdata_q;
  logic   bypass_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
    wdata_q <= wdata_i;
  end

  // a write to the address being read returns the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else begin
      bypass_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign head_o = bypass_q ? wdata_q : rdata_q;

endmodule

// File: rtl/teq_exec.sv
// queue pointers, axis counters and the per-word update logic
module teq_exec
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_SIZE = QueueSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_running_i,
  input  logic                          item_valid_i,
  input  item_t                         item_i,
  input  event_t                        head_i,
  output logic                          we_o,
  output logic [$clog2(QUEUE_SIZE)-1:0] waddr_o,
  output event_t                        wdata_o,
  output logic [$clog2(QUEUE_SIZE)-1:0] raddr_o,
  output result_t                       result_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_SIZE);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QUEUE_SIZE - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  logic [PtrW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic signed [31:0] theta_q, theta_d, rho_q, rho_d;
  logic [31:0]        underrun_q, underrun_d;
  logic [1:0]         dir_q, dir_d;
  logic               running_q;

  logic               accepted, fired, is_empty, future;
  logic [31:0]        diff;
  logic [PtrW:0]      depth_full;

  assign is_empty = (wp_q == rp_q);
  assign diff     = head_i.exec_time - item_i.now_us;
  assign future   = (diff != 32'd0) && (diff < FutureWindowUs);

  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    theta_d    = theta_q;
    rho_d      = rho_q;
    underrun_d = underrun_q;
    dir_d      = dir_q;
    accepted   = 1'b0;
    fired      = 1'b0;
    if (item_valid_i) begin
      unique case (item_i.cmd)
        CMD_PUSH: begin
          if (ptr_inc(wp_q) != rp_q) begin
            wp_d     = ptr_inc(wp_q);
            accepted = 1'b1;
          end
        end
        CMD_TICK: begin
          if (is_empty) begin
            if (running_q) begin
              underrun_d = underrun_q + 32'd1;
            end
          end else if (!future) begin
            fired = 1'b1;
            rp_d  = ptr_inc(rp_q);
            if (head_i.step_mask[AxisTheta]) begin
              dir_d[AxisTheta] = head_i.dir_mask[AxisTheta];
              theta_d = head_i.dir_mask[AxisTheta] ? theta_q + 32'sd1 : theta_q - 32'sd1;
            end
            if (head_i.step_mask[AxisRho]) begin
              dir_d[AxisRho] = head_i.dir_mask[AxisRho];
              rho_d = head_i.dir_mask[AxisRho] ? rho_q + 32'sd1 : rho_q - 32'sd1;
            end
          end
        end
        CMD_FLUSH: begin
          wp_d = '0;
          rp_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (wp_d >= rp_d) begin
      depth_full = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      depth_full = (PtrW+1)'(QUEUE_SIZE) - ({1'b0, rp_d} - {1'b0, wp_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      theta_q    <= '0;
      rho_q      <= '0;
      underrun_q <= '0;
      dir_q      <= '0;
      running_q  <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      theta_q    <= theta_d;
      rho_q      <= rho_d;
      underrun_q <= underrun_d;
      dir_q      <= dir_d;
      if (cfg_we_i) begin
        running_q <= cfg_running_i;
      end
    end
  end

  // memory read follows the next head so the head word is ready in the following cycle
  assign we_o    = accepted;
  assign waddr_o = wp_q;
  assign wdata_o = item_i.ev;
  assign raddr_o = rp_d;

  always_comb begin
    result_o.push_accepted  = accepted;
    result_o.fired          = fired;
    result_o.step_pulse     = fired ? head_i.step_mask : 2'b00;
    result_o.dir_pins       = dir_d;
    result_o.theta_position = theta_d;
    result_o.rho_position   = rho_d;
    result_o.queue_depth    = (32'(depth_full) > 32'(DepthMax)) ? DepthMax : 8'(depth_full);
    result_o.underrun_count = underrun_d;
  end

endmodule

// File: rtl/timed_step_event_queue.sv
// top level of the timed step event queue for two stepper axes
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser cmd, tdata event and time
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata status and positions
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | motion_running bit
//
// one word per cycle while the output is not stalled; its result is in the output register on the next cycle.
// the head event comes from a registered memory read addressed by the next read pointer.
// reset clears pointers, counters and pin levels; the event memory is not cleared.
// a stalled output word holds s_axis_tready low until m_axis takes it.
module timed_step_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_SIZE = QueueSizeDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // event_time[31:0], step_mask[33:32], dir_mask[35:34], now_us[67:36], zero fill
  input  logic [71:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // push_accepted[0], fired[1], step_pulse[3:2], dir_pins[5:4], theta_position[37:6],
  // rho_position[69:38], queue_depth[77:70], underrun_count[109:78], zero fill
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_SIZE);

  logic            in_fire;
  item_t           item;
  event_t          head, wdata;
  logic            we;
  logic [PtrW-1:0] waddr, raddr;
  result_t         result, res_q;
  logic            out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign item.cmd          = s_axis_tuser;
  assign item.ev.exec_time = s_axis_tdata[31:0];
  assign item.ev.step_mask = s_axis_tdata[33:32];
  assign item.ev.dir_mask  = s_axis_tdata[35:34];
  assign item.now_us       = s_axis_tdata[67:36];

  teq_store #(
    .QUEUE_SIZE(QUEUE_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .head_o (head)
  );

  teq_exec #(
    .QUEUE_SIZE(QUEUE_SIZE)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_running_i(cfg_data_i),
    .item_valid_i (in_fire),
    .item_i       (item),
    .head_i       (head),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.underrun_count, res_q.queue_depth,
                          res_q.rho_position, res_q.theta_position, res_q.dir_pins,
                          res_q.step_pulse, res_q.fired, res_q.push_accepted};

endmodule
